// File: hdl/mcm_pkg.sv
// Shared types and constants for the matrix chain order block.
// No dependencies; every other file of the block uses this package.
package mcm_pkg;

    localparam int DEF_MAX_MATRICES = 16;
    localparam int DEF_DIM_BITS     = 12;

    localparam int DIM_W    = 12;
    localparam int COST_W   = 40;
    localparam int SPLIT_W  = 4;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_TOO_MANY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_TOO_FEW  = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] dim_value;
        logic             last_dim;
    } t_in_beat;

    typedef struct packed {
        logic [COST_W-1:0]   chain_cost;
        logic [SPLIT_W-1:0]  split_pos;
        logic [STATUS_W-1:0] status;
    } t_out_beat;

    typedef struct packed {
        logic valid;
        logic head;
        logic first;
        logic last;
        logic full;
    } t_tag;

endpackage

// File: hdl/matrix_chain_order_dp_top.sv
// Matrix chain order: loads one dimension per beat, then runs the interval
// dynamic program with the cost table in RAM. An input beat is taken every
// cycle while loading; the closing beat of a chain of n matrices (n >= 2) starts
// the compute, which issues one split per cycle from the cost RAM read ports,
// plus one dimension fetch per interval and a pipeline drain per interval
// length; input is stalled throughout the compute. Error chains and single
// matrices answer in the cycle after the closing beat. A finished result waits
// in an output register; loading of the next chain goes on meanwhile, and only
// its closing beat waits for the result to be taken.
// Depends on mcm_pkg, mcm_ram and mcm_path.
module matrix_chain_order_dp_top #(
    parameter int MAX_MATRICES = mcm_pkg::DEF_MAX_MATRICES,
    parameter int DIM_BITS     = mcm_pkg::DEF_DIM_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mcm_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mcm_pkg::t_out_beat o_out_data
);
    import mcm_pkg::*;

    localparam int SLOTS = MAX_MATRICES + 1;
    localparam int IW    = $clog2(MAX_MATRICES);
    localparam int DAW   = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int CAW   = $clog2(MAX_MATRICES * MAX_MATRICES);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_ISSUE = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_ovf, n_ovf;
    logic [DAW-1:0]  r_n, n_n;
    logic [DAW-1:0]  r_len, n_len;
    logic [IW-1:0]   r_a, n_a;
    logic [IW-1:0]   r_k, n_k;
    logic            r_head, n_head;
    logic            r_done, n_done;
    t_tag            r_t1, n_t1;
    logic [IW-1:0]   r_k1;
    logic [CAW-1:0]  r_wa1;
    logic            r_out_valid, n_out_valid;
    t_out_beat       r_out, n_out;

    logic                accept;
    logic                has_slot;
    logic                ovf_now;
    logic [CW-1:0]       cnt_now;
    logic [DIM_BITS-1:0] dim_in;
    logic [IW-1:0]       b_idx;
    logic [IW-1:0]       k_next;
    logic                seg_last;
    logic                len_last;
    logic [DAW-1:0]      dim_ra0;
    logic [DAW-1:0]      dim_ra1;
    logic [CAW-1:0]      cost_ra0;
    logic [CAW-1:0]      cost_ra1;
    logic [CAW-1:0]      issue_wa;
    logic                busy;

    logic [DIM_BITS-1:0] dim_rd0, dim_rd1;
    logic [COST_W-1:0]   cost_rd0, cost_rd1;
    logic                path_busy;
    logic                cost_we;
    logic [CAW-1:0]      cost_wa;
    logic [COST_W-1:0]   cost_wd;
    logic                res_valid;
    logic [COST_W-1:0]   res_cost;
    logic [SPLIT_W-1:0]  res_split;

    assign o_in_stall = (r_state != ST_LOAD) || (r_out_valid && i_in_data.last_dim);
    assign accept     = i_in_valid && !o_in_stall;
    assign dim_in     = DIM_BITS'(i_in_data.dim_value);
    assign has_slot   = r_count < CW'(SLOTS);
    assign cnt_now    = r_count + CW'(has_slot);
    assign ovf_now    = r_ovf || !has_slot;

    assign b_idx    = IW'(DAW'(r_a) + r_len - DAW'(1));
    assign k_next   = r_k + IW'(1);
    assign seg_last = (k_next == b_idx);
    assign len_last = (DAW'(r_a) + r_len) == r_n;

    assign dim_ra0  = r_head ? DAW'(r_a) : DAW'(k_next);
    assign dim_ra1  = DAW'(b_idx) + DAW'(1);
    assign cost_ra0 = CAW'(r_a) * CAW'(MAX_MATRICES) + CAW'(r_k);
    assign cost_ra1 = CAW'(k_next) * CAW'(MAX_MATRICES) + CAW'(b_idx);
    assign issue_wa = CAW'(r_a) * CAW'(MAX_MATRICES) + CAW'(b_idx);

    assign busy = r_t1.valid || path_busy;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_len       = r_len;
        n_a         = r_a;
        n_k         = r_k;
        n_head      = r_head;
        n_done      = r_done;
        n_t1        = '0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;

        if (res_valid) begin
            n_out_valid      = 1'b1;
            n_out.chain_cost = res_cost;
            n_out.split_pos  = res_split;
            n_out.status     = STAT_OK;
        end

        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    n_count = cnt_now;
                    n_ovf   = ovf_now;
                    if (i_in_data.last_dim) begin
                        n_count          = '0;
                        n_ovf            = 1'b0;
                        n_out.chain_cost = '0;
                        n_out.split_pos  = '0;
                        n_out.status     = STAT_OK;
                        if (ovf_now) begin
                            n_out_valid  = 1'b1;
                            n_out.status = STAT_TOO_MANY;
                        end else if (cnt_now < CW'(2)) begin
                            n_out_valid  = 1'b1;
                            n_out.status = STAT_TOO_FEW;
                        end else if (cnt_now == CW'(2)) begin
                            n_out_valid = 1'b1;
                        end else begin
                            n_n     = DAW'(cnt_now - CW'(1));
                            n_len   = DAW'(2);
                            n_a     = '0;
                            n_k     = '0;
                            n_head  = 1'b1;
                            n_state = ST_ISSUE;
                        end
                    end
                end
            end
            ST_ISSUE: begin
                n_t1.valid = 1'b1;
                n_t1.head  = r_head;
                n_t1.first = !r_head && (r_k == r_a);
                n_t1.last  = !r_head && seg_last;
                n_t1.full  = (r_len == r_n);
                if (r_head) begin
                    n_head = 1'b0;
                    n_k    = r_a;
                end else if (seg_last) begin
                    n_head = 1'b1;
                    if (len_last) begin
                        n_done  = (r_len == r_n);
                        n_len   = r_len + DAW'(1);
                        n_a     = '0;
                        n_state = ST_DRAIN;
                    end else begin
                        n_a = r_a + IW'(1);
                    end
                end else begin
                    n_k = k_next;
                end
            end
            ST_DRAIN: begin
                if (!busy) begin
                    n_state = r_done ? ST_LOAD : ST_ISSUE;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_t1        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_t1        <= n_t1;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_len  <= n_len;
        r_a    <= n_a;
        r_k    <= n_k;
        r_head <= n_head;
        r_done <= n_done;
        r_k1   <= r_k;
        r_wa1  <= issue_wa;
        r_out  <= n_out;
    end

    mcm_ram #(
        .WIDTH (DIM_BITS),
        .DEPTH (SLOTS)
    ) u_dim_ram (
        .i_clk    (i_clk),
        .i_we     (accept && has_slot),
        .i_waddr  (r_count[DAW-1:0]),
        .i_wdata  (dim_in),
        .i_raddr0 (dim_ra0),
        .i_raddr1 (dim_ra1),
        .o_rdata0 (dim_rd0),
        .o_rdata1 (dim_rd1)
    );

    mcm_ram #(
        .WIDTH (COST_W),
        .DEPTH (MAX_MATRICES * MAX_MATRICES)
    ) u_cost_ram (
        .i_clk    (i_clk),
        .i_we     (cost_we),
        .i_waddr  (cost_wa),
        .i_wdata  (cost_wd),
        .i_raddr0 (cost_ra0),
        .i_raddr1 (cost_ra1),
        .o_rdata0 (cost_rd0),
        .o_rdata1 (cost_rd1)
    );

    mcm_path #(
        .MAX_MATRICES (MAX_MATRICES),
        .DIM_BITS     (DIM_BITS)
    ) u_path (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tag       (r_t1),
        .i_k         (r_k1),
        .i_waddr     (r_wa1),
        .i_dim0      (dim_rd0),
        .i_dim1      (dim_rd1),
        .i_cost0     (cost_rd0),
        .i_cost1     (cost_rd1),
        .o_busy      (path_busy),
        .o_we        (cost_we),
        .o_waddr     (cost_wa),
        .o_wdata     (cost_wd),
        .o_res_valid (res_valid),
        .o_res_cost  (res_cost),
        .o_res_split (res_split)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: hdl/mcm_ram.sv
// Generic simple dual-read RAM: one write port, two registered read ports.
// No dependencies beyond the shared package for default sizes.
module mcm_ram #(
    parameter  int WIDTH = mcm_pkg::COST_W,
    parameter  int DEPTH = mcm_pkg::DEF_MAX_MATRICES * mcm_pkg::DEF_MAX_MATRICES,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr0,
    input  logic [AW-1:0]    i_raddr1,
    output logic [WIDTH-1:0] o_rdata0,
    output logic [WIDTH-1:0] o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// File: hdl/mcm_path.sv
// Split evaluation pipeline: product of three dimensions, cost sum, saturation,
// running minimum per interval and cost table write-back. Depends on mcm_pkg.
module mcm_path #(
    parameter  int MAX_MATRICES = mcm_pkg::DEF_MAX_MATRICES,
    parameter  int DIM_BITS     = mcm_pkg::DEF_DIM_BITS,
    localparam int IW           = $clog2(MAX_MATRICES),
    localparam int CAW          = $clog2(MAX_MATRICES * MAX_MATRICES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mcm_pkg::t_tag                i_tag,
    input  logic [IW-1:0]                i_k,
    input  logic [CAW-1:0]               i_waddr,
    input  logic [DIM_BITS-1:0]          i_dim0,
    input  logic [DIM_BITS-1:0]          i_dim1,
    input  logic [mcm_pkg::COST_W-1:0]   i_cost0,
    input  logic [mcm_pkg::COST_W-1:0]   i_cost1,
    output logic                         o_busy,
    output logic                         o_we,
    output logic [CAW-1:0]               o_waddr,
    output logic [mcm_pkg::COST_W-1:0]   o_wdata,
    output logic                         o_res_valid,
    output logic [mcm_pkg::COST_W-1:0]   o_res_cost,
    output logic [mcm_pkg::SPLIT_W-1:0]  o_res_split
);
    import mcm_pkg::*;

    localparam int MW  = 2 * DIM_BITS;
    localparam int PW  = 3 * DIM_BITS;
    localparam int CSW = COST_W + 1;
    localparam int SW  = ((PW > CSW) ? PW : CSW) + 1;

    logic [DIM_BITS-1:0] r_pa;
    logic [DIM_BITS-1:0] r_pb;

    t_tag                r_t2;
    logic [MW-1:0]       r_m2;
    logic [DIM_BITS-1:0] r_pb2;
    logic [CSW-1:0]      r_c2;
    logic [IW-1:0]       r_k2;
    logic [CAW-1:0]      r_wa2;

    t_tag                r_t3;
    logic [PW-1:0]       r_p3;
    logic [CSW-1:0]      r_c3;
    logic [IW-1:0]       r_k3;
    logic [CAW-1:0]      r_wa3;

    t_tag                r_t4;
    logic [COST_W-1:0]   r_q4;
    logic [IW-1:0]       r_k4;
    logic [CAW-1:0]      r_wa4;

    logic [COST_W-1:0]   r_best;
    logic [IW-1:0]       r_bestk;

    t_tag                n_t2;
    logic [CSW-1:0]      n_c2;
    logic [SW-1:0]       sum3;
    logic [COST_W-1:0]   n_q4;
    logic                take;
    logic [COST_W-1:0]   n_best;
    logic [IW-1:0]       n_bestk;

    always_comb begin
        n_t2       = i_tag;
        n_t2.valid = i_tag.valid && !i_tag.head;
        n_c2 = (i_tag.first ? '0 : CSW'(i_cost0)) + (i_tag.last ? '0 : CSW'(i_cost1));
    end

    assign sum3 = SW'(r_c3) + SW'(r_p3);
    assign n_q4 = (|sum3[SW-1:COST_W]) ? '1 : sum3[COST_W-1:0];

    assign take    = r_t4.first || (r_q4 < r_best);
    assign n_best  = take ? r_q4 : r_best;
    assign n_bestk = take ? (r_k4 + IW'(1)) : r_bestk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t2 <= '0;
            r_t3 <= '0;
            r_t4 <= '0;
        end else begin
            r_t2 <= n_t2;
            r_t3 <= r_t2;
            r_t4 <= r_t3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tag.valid && i_tag.head) begin
            r_pa <= i_dim0;
            r_pb <= i_dim1;
        end
        r_m2  <= MW'(r_pa) * MW'(i_dim0);
        r_pb2 <= r_pb;
        r_c2  <= n_c2;
        r_k2  <= i_k;
        r_wa2 <= i_waddr;

        r_p3  <= PW'(r_m2) * PW'(r_pb2);
        r_c3  <= r_c2;
        r_k3  <= r_k2;
        r_wa3 <= r_wa2;

        r_q4  <= n_q4;
        r_k4  <= r_k3;
        r_wa4 <= r_wa3;

        if (r_t4.valid) begin
            r_best  <= n_best;
            r_bestk <= n_bestk;
        end
    end

    assign o_busy      = r_t2.valid || r_t3.valid || r_t4.valid;
    assign o_we        = r_t4.valid && r_t4.last;
    assign o_waddr     = r_wa4;
    assign o_wdata     = n_best;
    assign o_res_valid = o_we && r_t4.full;
    assign o_res_cost  = n_best;
    assign o_res_split = SPLIT_W'(n_bestk);

endmodule
